// File: src/ajnm_pkg.sv
// shared constants and types for the as-of join nearest match block
package ajnm_pkg;

    localparam int TIME_BITS           = 64;
    localparam int DEF_TABLE_DEPTH     = 64;
    localparam int DEF_KEY_BITS        = 16;
    localparam int DEF_INDEX_BITS      = 20;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_PROBE = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    typedef struct packed {
        logic load;
        logic probe;
        logic drain;
    } ajnm_op_t;

endpackage

// File: src/ajnm_cell.sv
// one table cell of the sorted chain: holds an entry, inserts, probes and shifts
module ajnm_cell
    import ajnm_pkg::*;
#(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ajnm_op_t              op,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [TIME_BITS-1:0]  new_time,
    input  logic [INDEX_BITS-1:0] new_index,
    input  logic                  left_before,
    input  logic                  left_hit,
    input  logic                  left_valid,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [TIME_BITS-1:0]  left_time,
    input  logic [INDEX_BITS-1:0] left_order,
    input  logic [TIME_BITS-1:0]  left_gap,
    input  logic [INDEX_BITS-1:0] left_price,
    input  logic                  left_matched,
    input  logic                  right_valid,
    input  logic [KEY_BITS-1:0]   right_key,
    input  logic [TIME_BITS-1:0]  right_time,
    input  logic [INDEX_BITS-1:0] right_order,
    input  logic [TIME_BITS-1:0]  right_gap,
    input  logic [INDEX_BITS-1:0] right_price,
    input  logic                  right_matched,
    output logic                  precedes,
    output logic                  hit,
    output logic                  valid,
    output logic [KEY_BITS-1:0]   key,
    output logic [TIME_BITS-1:0]  time_val,
    output logic [INDEX_BITS-1:0] order,
    output logic [TIME_BITS-1:0]  gap,
    output logic [INDEX_BITS-1:0] price,
    output logic                  matched
);

    logic                  valid_reg,   valid_next;
    logic                  matched_reg, matched_next;
    logic [KEY_BITS-1:0]   key_reg,     key_next;
    logic [TIME_BITS-1:0]  time_reg,    time_next;
    logic [INDEX_BITS-1:0] order_reg,   order_next;
    logic [TIME_BITS-1:0]  gap_reg,     gap_next;
    logic [INDEX_BITS-1:0] price_reg,   price_next;
    logic [TIME_BITS-1:0]  probe_gap;

    assign precedes = valid_reg && ((key_reg < new_key) ||
                      ((key_reg == new_key) && (time_reg <= new_time)));
    assign hit    = valid_reg && (key_reg == new_key) && (time_reg >= new_time);
    assign probe_gap = time_reg - new_time;

    always_comb
    begin
        valid_next   = valid_reg;
        matched_next = matched_reg;
        key_next     = key_reg;
        time_next    = time_reg;
        order_next   = order_reg;
        gap_next     = gap_reg;
        price_next   = price_reg;
        if (op.load && !precedes)
        begin
            if (left_before)
            begin
                valid_next   = 1'b1;
                matched_next = 1'b0;
                key_next     = new_key;
                time_next    = new_time;
                order_next   = new_index;
                gap_next     = '1;
                price_next   = '0;
            end
            else
            begin
                valid_next   = left_valid;
                matched_next = left_matched;
                key_next     = left_key;
                time_next    = left_time;
                order_next   = left_order;
                gap_next     = left_gap;
                price_next   = left_price;
            end
        end
        else if (op.probe && hit && !left_hit)
        begin
            matched_next = 1'b1;
            if (probe_gap < gap_reg)
            begin
                gap_next   = probe_gap;
                price_next = new_index;
            end
        end
        else if (op.drain)
        begin
            valid_next   = right_valid;
            matched_next = right_matched;
            key_next     = right_key;
            time_next    = right_time;
            order_next   = right_order;
            gap_next     = right_gap;
            price_next   = right_price;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            matched_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            matched_reg <= matched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        time_reg  <= time_next;
        order_reg <= order_next;
        gap_reg   <= gap_next;
        price_reg <= price_next;
    end

    assign valid    = valid_reg;
    assign matched  = matched_reg;
    assign key      = key_reg;
    assign time_val = time_reg;
    assign order    = order_reg;
    assign gap      = gap_reg;
    assign price    = price_reg;

endmodule

// File: src/asof_join_nearest_match.sv
// top level: sorted cell chain, carried match and registered drain output
// a drain request that finds a pair gives its result on out_valid in the cycle after acceptance
// throughput: one request per cycle while in_stall is low; every cell compares against the broadcast request
// a drain request is stalled only while an earlier result sits stalled at the output
// reset clears the cell valid and matched bits, the carried match and the overflow flag
// no clearing pass after reset; the block takes requests from the first cycle
module asof_join_nearest_match
    import ajnm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int INDEX_BITS  = DEF_INDEX_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [KEY_BITS-1:0]   stock_key,
    input  logic [TIME_BITS-1:0]  time_value,
    input  logic [INDEX_BITS-1:0] row_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [INDEX_BITS-1:0] price_index,
    output logic [INDEX_BITS-1:0] order_index,
    output logic [KEY_BITS-1:0]   out_key,
    output logic                  table_now_empty,
    output logic                  overflow_seen
);

    logic [TABLE_DEPTH-1:0]  c_before;
    logic [TABLE_DEPTH-1:0]  c_hit;
    logic [TABLE_DEPTH-1:0]  c_valid;
    logic [TABLE_DEPTH-1:0]  c_matched;
    logic [KEY_BITS-1:0]     c_key   [TABLE_DEPTH];
    logic [TIME_BITS-1:0]    c_time  [TABLE_DEPTH];
    logic [INDEX_BITS-1:0]   c_order [TABLE_DEPTH];
    logic [TIME_BITS-1:0]    c_gap   [TABLE_DEPTH];
    logic [INDEX_BITS-1:0]   c_price [TABLE_DEPTH];

    ajnm_op_t                op;
    logic                    accept;
    logic                    full;
    logic                    do_drain;
    logic                    paired;

    logic                    carry_valid_reg, carry_valid_next;
    logic [INDEX_BITS-1:0]   carry_price_reg, carry_price_next;
    logic [KEY_BITS-1:0]     carry_key_reg,   carry_key_next;
    logic                    dropped_reg,     dropped_next;
    logic                    out_valid_reg,   out_valid_next;
    logic [INDEX_BITS-1:0]   price_reg;
    logic [INDEX_BITS-1:0]   order_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic                    empty_reg;
    logic                    ovf_reg;

    assign in_stall = out_valid_reg && out_stall && (kind == KIND_DRAIN);
    assign accept   = in_valid && !in_stall;
    assign full     = c_valid[TABLE_DEPTH-1];
    assign do_drain = accept && (kind == KIND_DRAIN) && c_valid[0];

    assign op.load  = accept && (kind == KIND_LOAD) && !full;
    assign op.probe = accept && (kind == KIND_PROBE);
    assign op.drain = do_drain;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic                  l_before, l_hit, l_valid, l_matched;
            logic [KEY_BITS-1:0]   l_key;
            logic [TIME_BITS-1:0]  l_time, l_gap;
            logic [INDEX_BITS-1:0] l_order, l_price;
            logic                  r_valid, r_matched;
            logic [KEY_BITS-1:0]   r_key;
            logic [TIME_BITS-1:0]  r_time, r_gap;
            logic [INDEX_BITS-1:0] r_order, r_price;

            if (gi == 0)
            begin : g_head
                assign l_before  = 1'b1;
                assign l_hit     = 1'b0;
                assign l_valid   = 1'b0;
                assign l_matched = 1'b0;
                assign l_key     = '0;
                assign l_time    = '0;
                assign l_gap     = '0;
                assign l_order   = '0;
                assign l_price   = '0;
            end
            else
            begin : g_left
                assign l_before  = c_before[gi-1];
                assign l_hit     = c_hit[gi-1];
                assign l_valid   = c_valid[gi-1];
                assign l_matched = c_matched[gi-1];
                assign l_key     = c_key[gi-1];
                assign l_time    = c_time[gi-1];
                assign l_gap     = c_gap[gi-1];
                assign l_order   = c_order[gi-1];
                assign l_price   = c_price[gi-1];
            end

            if (gi == TABLE_DEPTH-1)
            begin : g_tail
                assign r_valid   = 1'b0;
                assign r_matched = 1'b0;
                assign r_key     = '0;
                assign r_time    = '0;
                assign r_gap     = '0;
                assign r_order   = '0;
                assign r_price   = '0;
            end
            else
            begin : g_right
                assign r_valid   = c_valid[gi+1];
                assign r_matched = c_matched[gi+1];
                assign r_key     = c_key[gi+1];
                assign r_time    = c_time[gi+1];
                assign r_gap     = c_gap[gi+1];
                assign r_order   = c_order[gi+1];
                assign r_price   = c_price[gi+1];
            end

            ajnm_cell #(
                .KEY_BITS   (KEY_BITS),
                .INDEX_BITS (INDEX_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .op            (op),
                .new_key       (stock_key),
                .new_time      (time_value),
                .new_index     (row_index),
                .left_before   (l_before),
                .left_hit      (l_hit),
                .left_valid    (l_valid),
                .left_key      (l_key),
                .left_time     (l_time),
                .left_order    (l_order),
                .left_gap      (l_gap),
                .left_price    (l_price),
                .left_matched  (l_matched),
                .right_valid   (r_valid),
                .right_key     (r_key),
                .right_time    (r_time),
                .right_order   (r_order),
                .right_gap     (r_gap),
                .right_price   (r_price),
                .right_matched (r_matched),
                .precedes      (c_before[gi]),
                .hit           (c_hit[gi]),
                .valid         (c_valid[gi]),
                .key           (c_key[gi]),
                .time_val      (c_time[gi]),
                .order         (c_order[gi]),
                .gap           (c_gap[gi]),
                .price         (c_price[gi]),
                .matched       (c_matched[gi])
            );
        end
    endgenerate

    logic [INDEX_BITS-1:0] sel_price;
    logic [KEY_BITS-1:0]   sel_key;
    logic                  sel_valid;
    logic                  last_out;

    assign sel_valid = c_matched[0] ? 1'b1 : carry_valid_reg;
    assign sel_price = c_matched[0] ? c_price[0] : carry_price_reg;
    assign sel_key   = c_matched[0] ? c_key[0] : carry_key_reg;
    assign paired    = sel_valid && (sel_key == c_key[0]);
    assign last_out  = (TABLE_DEPTH > 1) ? !c_valid[1 % TABLE_DEPTH] : 1'b1;

    always_comb
    begin
        carry_valid_next = carry_valid_reg;
        carry_price_next = carry_price_reg;
        carry_key_next   = carry_key_reg;
        dropped_next     = dropped_reg;
        out_valid_next   = out_valid_reg && out_stall;
        if (accept && (kind == KIND_LOAD) && full)
        begin
            dropped_next = 1'b1;
        end
        if (do_drain)
        begin
            if (last_out)
            begin
                carry_valid_next = 1'b0;
                carry_price_next = '0;
                carry_key_next   = '0;
            end
            else
            begin
                carry_valid_next = sel_valid;
                carry_price_next = sel_price;
                carry_key_next   = sel_key;
            end
            if (paired)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_valid_reg <= 1'b0;
            carry_price_reg <= '0;
            carry_key_reg   <= '0;
            dropped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            carry_valid_reg <= carry_valid_next;
            carry_price_reg <= carry_price_next;
            carry_key_reg   <= carry_key_next;
            dropped_reg     <= dropped_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_drain && paired)
        begin
            price_reg <= sel_price;
            order_reg <= c_order[0];
            key_reg   <= c_key[0];
            empty_reg <= last_out;
            ovf_reg   <= dropped_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign price_index     = price_reg;
    assign order_index     = order_reg;
    assign out_key         = key_reg;
    assign table_now_empty = empty_reg;
    assign overflow_seen   = ovf_reg;

    // occupied cells always form an unbroken run from the head
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid & (c_valid + 1'b1)) == '0)
        else $error("cell valid bits not contiguous");

    a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |=> dropped_reg)
        else $error("overflow flag cleared");

    a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_LOAD) && full) |=> dropped_reg && $stable(c_valid))
        else $error("load into full table not dropped");

    a_load_grow: assert property (@(posedge clk) disable iff (!rst_n)
        op.load |=> $countones(c_valid) == $countones($past(c_valid)) + 1)
        else $error("load did not add one entry");

    a_drain_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        op.drain |=> $countones(c_valid) + 1 == $countones($past(c_valid)))
        else $error("drain did not remove one entry");

endmodule

// File: bench/asof_join_nearest_match_test.sv
// self-checking testbench for the as-of join nearest match block
module asof_join_nearest_match_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ajnm_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int KW = DEF_KEY_BITS;
    localparam int IW = DEF_INDEX_BITS;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int REPORT_LIMIT = 10;

    typedef logic [KW-1:0] key_t;
    typedef logic [TIME_BITS-1:0] stamp_t;
    typedef logic [IW-1:0] index_t;

    typedef struct packed {
        key_t   key;
        stamp_t stamp;
        index_t order;
        stamp_t best_gap;
        index_t best_price;
        logic   matched;
    } book_entry_t;

    typedef struct packed {
        index_t price;
        index_t order;
        key_t   key;
        logic   now_empty;
        logic   overflow;
    } joined_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] kind = KIND_LOAD;
    key_t stock_key = '0;
    stamp_t time_value = '0;
    index_t row_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    index_t price_index;
    index_t order_index;
    key_t out_key;
    logic table_now_empty;
    logic overflow_seen;

    book_entry_t book[DEPTH];
    int book_fill = 0;
    logic carry_on = 1'b0;
    index_t carry_price = '0;
    key_t carry_key = '0;
    logic book_dropped = 1'b0;
    joined_pair_t pending_pairs[$];
    joined_pair_t arrived_want;
    int fail_count = 0;
    int request_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    asof_join_nearest_match u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .stock_key       (stock_key),
        .time_value      (time_value),
        .row_index       (row_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .price_index     (price_index),
        .order_index     (order_index),
        .out_key         (out_key),
        .table_now_empty (table_now_empty),
        .overflow_seen   (overflow_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic stamp_t any_stamp();
        return {$urandom, $urandom};
    endfunction

    function automatic void predict_join(logic [1:0] req_kind, key_t req_key,
                                         stamp_t req_stamp, index_t req_index);
        int pos;
        bit found;
        book_entry_t head;
        joined_pair_t pair;
        pos = 0;
        found = 1'b0;
        case (req_kind)
            KIND_LOAD:
            begin
                if (book_fill >= DEPTH)
                begin
                    book_dropped = 1'b1;
                end
                else
                begin
                    while (pos < book_fill && (book[pos].key < req_key ||
                           (book[pos].key == req_key && book[pos].stamp <= req_stamp)))
                        pos++;
                    for (int i = book_fill; i > pos; i--)
                        book[i] = book[i-1];
                    book[pos].key = req_key;
                    book[pos].stamp = req_stamp;
                    book[pos].order = req_index;
                    book[pos].best_gap = '1;
                    book[pos].best_price = '0;
                    book[pos].matched = 1'b0;
                    book_fill++;
                end
            end
            KIND_PROBE:
            begin
                for (int i = 0; i < book_fill && !found; i++)
                begin
                    if (book[i].key == req_key && book[i].stamp >= req_stamp)
                    begin
                        found = 1'b1;
                        if (stamp_t'(book[i].stamp - req_stamp) < book[i].best_gap)
                        begin
                            book[i].best_gap = book[i].stamp - req_stamp;
                            book[i].best_price = req_index;
                        end
                        book[i].matched = 1'b1;
                    end
                end
            end
            KIND_DRAIN:
            begin
                if (book_fill > 0)
                begin
                    head = book[0];
                    if (head.matched)
                    begin
                        carry_on = 1'b1;
                        carry_price = head.best_price;
                        carry_key = head.key;
                    end
                    for (int i = 1; i < book_fill; i++)
                        book[i-1] = book[i];
                    book_fill--;
                    pair.price = carry_price;
                    pair.order = head.order;
                    pair.key = head.key;
                    pair.now_empty = (book_fill == 0);
                    pair.overflow = book_dropped;
                    if (carry_on && carry_key == head.key)
                        pending_pairs.push_back(pair);
                    if (book_fill == 0)
                    begin
                        carry_on = 1'b0;
                        carry_price = '0;
                        carry_key = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_request(logic [1:0] req_kind, key_t req_key,
                                stamp_t req_stamp, index_t req_index);
        int idle;
        idle = 0;
        while ($urandom_range(0, 99) < idle_pct)
            idle++;
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= req_kind;
        stock_key <= req_key;
        time_value <= req_stamp;
        row_index <= req_index;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_join(req_kind, req_key, req_stamp, req_index);
        if (req_kind != KIND_SPARE)
            request_count++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pairs.size() > 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_pairs.size() == 0)
            begin
                note_failure($sformatf("pair with no request: price %h order %h key %h",
                                       price_index, order_index, out_key));
            end
            else
            begin
                arrived_want = pending_pairs.pop_front();
                if (price_index !== arrived_want.price ||
                    order_index !== arrived_want.order ||
                    out_key !== arrived_want.key ||
                    table_now_empty !== arrived_want.now_empty ||
                    overflow_seen !== arrived_want.overflow)
                    note_failure($sformatf(
                        "pair mismatch: want %h/%h/%h/%b/%b got %h/%h/%h/%b/%b",
                        arrived_want.price, arrived_want.order, arrived_want.key,
                        arrived_want.now_empty, arrived_want.overflow,
                        price_index, order_index, out_key,
                        table_now_empty, overflow_seen));
            end
        end
    end

    task automatic test_directed_cases();
        idle_pct = 0;
        stall_pct = 0;
        // drain while empty
        send_request(KIND_DRAIN, '0, '0, '0);
        send_request(KIND_LOAD, '1, '1, '1);
        send_request(KIND_LOAD, '0, '0, '0);
        send_request(KIND_LOAD, 16'h0005, 64'd100, 20'h00001);
        // equal key and time goes after the stored one
        send_request(KIND_LOAD, 16'h0005, 64'd100, 20'h00002);
        send_request(KIND_LOAD, 16'h0005, 64'd200, 20'h00003);
        send_request(KIND_PROBE, 16'h0005, 64'd100, 20'h00007);
        // worse gap, still matched
        send_request(KIND_PROBE, 16'h0005, 64'd90, 20'h00008);
        send_request(KIND_PROBE, 16'h0005, 64'd150, 20'h00009);
        // no entry selected
        send_request(KIND_PROBE, 16'h0006, 64'd0, 20'h0000a);
        send_request(KIND_PROBE, '0, '0, 20'habcde);
        // full-span gap keeps price zero
        send_request(KIND_PROBE, '1, '0, '1);
        send_request(KIND_SPARE, '1, '1, '1);
        repeat (5) send_request(KIND_DRAIN, '0, '0, '0);
        send_request(KIND_LOAD, 16'h0009, 64'd10, 20'h00011);
        send_request(KIND_LOAD, 16'h0009, 64'd20, 20'h00012);
        send_request(KIND_PROBE, 16'h0009, 64'd15, 20'h00033);
        // first drain has no pair
        repeat (3) send_request(KIND_DRAIN, '0, '0, '0);
        hold_until_drained();
    endtask

    task automatic test_join_traffic(int sender_idle, int receiver_stall, int budget);
        key_t pool[3];
        stamp_t base;
        int goal;
        int loads;
        int probes;
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        goal = request_count + budget;
        while (request_count < goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(2'($urandom_range(0, 3)), key_t'($urandom), any_stamp(),
                             index_t'($urandom));
            end
            else
            begin
                foreach (pool[j])
                    pool[j] = ($urandom_range(0, 7) == 0) ? key_t'('1) : key_t'($urandom);
                base = ($urandom_range(0, 3) == 0) ? ~stamp_t'(2000) : any_stamp();
                loads = $urandom_range(1, 24);
                probes = $urandom_range(0, 2 * loads);
                repeat (loads)
                    send_request(KIND_LOAD, pool[$urandom_range(0, 2)],
                                 base + stamp_t'($urandom_range(0, 1000)),
                                 index_t'($urandom));
                repeat (probes)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_request(KIND_DRAIN, key_t'($urandom), any_stamp(),
                                     index_t'($urandom));
                    else
                        send_request(KIND_PROBE,
                                     ($urandom_range(0, 9) == 0) ? key_t'($urandom)
                                                                : pool[$urandom_range(0, 2)],
                                     base + stamp_t'($urandom_range(0, 1100)) - stamp_t'(50),
                                     index_t'($urandom));
                end
                while (book_fill > 0)
                    send_request(KIND_DRAIN, key_t'($urandom), any_stamp(),
                                 index_t'($urandom));
            end
        end
        hold_until_drained();
    endtask

    task automatic test_full_table();
        key_t pool[2];
        stamp_t base;
        idle_pct = 28;
        stall_pct = 28;
        pool[0] = key_t'($urandom);
        pool[1] = key_t'($urandom);
        base = any_stamp();
        // the last few loads find the table full
        repeat (DEPTH + 3)
            send_request(KIND_LOAD, pool[$urandom_range(0, 1)],
                         base + stamp_t'($urandom_range(0, 500)), index_t'($urandom));
        repeat (16)
            send_request(KIND_PROBE, pool[$urandom_range(0, 1)],
                         base + stamp_t'($urandom_range(0, 500)), index_t'($urandom));
        while (book_fill > 0)
            send_request(KIND_DRAIN, '0, '0, '0);
        send_request(KIND_DRAIN, '1, '1, '1);
    endtask

    initial
    begin : stimulus
        int waited;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_join_traffic(0, 0, 250);
        test_join_traffic(66, 0, 250);
        test_join_traffic(0, 66, 250);
        test_join_traffic(28, 28, 250);
        test_full_table();
        in_valid <= 1'b0;
        waited = 0;
        while (pending_pairs.size() > 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (pending_pairs.size() > 0)
            note_failure($sformatf("%0d pairs never arrived", pending_pairs.size()));
        if (fail_count == 0)
            $display("asof_join_nearest_match test passed");
        else
            $display("asof_join_nearest_match test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("asof_join_nearest_match test failed");
        $finish;
    end

endmodule

// File: asof_join_nearest_match.f
src/ajnm_pkg.sv
src/ajnm_cell.sv
src/asof_join_nearest_match.sv
bench/asof_join_nearest_match_test.sv
